[rtl/mswd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mswd_pkg
// Shared types, constants and helpers of the multi-slot stall watchdog.
// ----------------------------------------------------------------------------
package mswd_pkg;

	localparam int SLOTS        = 8;
	localparam int VERSION_BITS = 16;
	localparam int MAX_ALERTS   = 8;
	localparam int IDX_W        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int ACT_W        = 4;
	localparam int CFG_IDX_W    = 2;

	localparam logic [ACT_W-1:0] ACT_LIMIT =
		ACT_W'((SLOTS < MAX_ALERTS) ? SLOTS : MAX_ALERTS);

	localparam logic [1:0] OP_ENTER = 2'd0;
	localparam logic [1:0] OP_LEAVE = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_SLOTS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MONITOR_EN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SENDER_ID    = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [2:0]  slot;
		logic [31:0] destination_id;
	} in_item_t;

	typedef struct packed {
		logic [31:0] alert_destination;
		logic [2:0]  alert_slot;
		logic [31:0] alert_sender;
		logic        last_alert;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic update;      // enter/leave on the accepted beat
		logic is_enter;
		logic scan_start;
		logic scan_step;
		logic push;        // move held alert into the output register
		logic push_last;
		logic clear_held;
	} ctl_cmd_t;

	typedef struct packed {
		logic slot_ok;
		logic enable;
		logic hit;
		logic scan_last;
		logic held_valid;
		logic out_free;
	} dp_sts_t;

	function automatic logic [ACT_W-1:0] clamp_slots(input logic [31:0] v);
		logic [ACT_W-1:0] n;
		n = v[ACT_W-1:0];
		if (n == '0)
			n = ACT_W'(1);
		if (n > ACT_LIMIT)
			n = ACT_LIMIT;
		return n;
	endfunction

endpackage
`default_nettype wire

[rtl/mswd_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mswd_ctrl
// Sequencer: takes input beats while idle, walks the slots on a tick and
// decides when a held alert may move into the output register.
// ----------------------------------------------------------------------------
module mswd_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic [1:0]          in_op,
	output logic                     in_stall,
	input  wire mswd_pkg::dp_sts_t   sts,
	output mswd_pkg::ctl_cmd_t       cmd
);
	import mswd_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					unique case (in_op) inside
						OP_ENTER, OP_LEAVE: begin
							cmd.update   = sts.slot_ok;
							cmd.is_enter = (in_op == OP_ENTER);
						end
						OP_TICK: begin
							if (sts.enable) begin
								cmd.scan_start = 1'b1;
								state_d        = ST_SCAN;
							end
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				// a second hit needs room for the one already held
				if (!(sts.hit && sts.held_valid && !sts.out_free)) begin
					cmd.scan_step = 1'b1;
					cmd.push      = sts.hit && sts.held_valid;
					if (sts.scan_last)
						state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!sts.held_valid) begin
					state_d = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.push       = 1'b1;
					cmd.push_last  = 1'b1;
					cmd.clear_held = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

[rtl/mswd_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mswd_dp
// Datapath: per-slot version and destination registers, configuration
// registers, scan index, one held alert and the output register.
// ----------------------------------------------------------------------------
module mswd_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire mswd_pkg::in_item_t            in_data,
	input  wire logic                          cfg_we,
	input  wire logic [mswd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                   cfg_data,
	input  wire mswd_pkg::ctl_cmd_t            cmd,
	output mswd_pkg::dp_sts_t                  sts,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output mswd_pkg::out_item_t                out_data
);
	import mswd_pkg::*;

	logic [VERSION_BITS-1:0] act_ver_q [SLOTS];
	logic [VERSION_BITS-1:0] chk_ver_q [SLOTS];
	logic [31:0]             dest_q    [SLOTS];

	logic [ACT_W-1:0] active_q;
	logic             enable_q;
	logic [31:0]      sender_q;

	logic [IDX_W-1:0] idx_q;
	logic             held_valid_q;
	logic [31:0]      held_dest_q;
	logic [IDX_W-1:0] held_slot_q;
	logic             out_valid_q;
	out_item_t        out_q;

	logic [IDX_W-1:0]        upd_idx;
	logic [IDX_W-1:0]        rd_idx;
	logic [VERSION_BITS-1:0] rd_act;
	logic [VERSION_BITS-1:0] rd_chk;
	logic [31:0]             rd_dest;
	logic                    same_ver;

	// update port and scan port read separately, so status never depends on commands
	assign upd_idx  = IDX_W'(in_data.slot);
	assign rd_idx   = idx_q;
	assign rd_act   = act_ver_q[rd_idx];
	assign rd_chk   = chk_ver_q[rd_idx];
	assign rd_dest  = dest_q[rd_idx];
	assign same_ver = (rd_act == rd_chk);

	assign sts.slot_ok    = ({{IDX_W{1'b0}}, in_data.slot} < (IDX_W + 3)'(SLOTS));
	assign sts.enable     = enable_q;
	assign sts.hit        = same_ver && (rd_dest != '0);
	assign sts.scan_last  = (({{ACT_W{1'b0}}, idx_q} + (IDX_W + ACT_W)'(1))
		== {{IDX_W{1'b0}}, active_q});
	assign sts.held_valid = held_valid_q;
	assign sts.out_free   = !out_valid_q || !out_stall;

	// slot state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				act_ver_q[i] <= '0;
				chk_ver_q[i] <= '0;
				dest_q[i]    <= '0;
			end
		end else if (cmd.update) begin
			dest_q[upd_idx]    <= cmd.is_enter ? in_data.destination_id : 32'd0;
			act_ver_q[upd_idx] <= act_ver_q[upd_idx] + VERSION_BITS'(1);
		end else if (cmd.scan_step) begin
			if (!same_ver)
				chk_ver_q[rd_idx] <= rd_act;
			else if (rd_dest != '0)
				dest_q[rd_idx] <= 32'd0;
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACT_W'(1);
			enable_q <= 1'b0;
			sender_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ACTIVE_SLOTS: active_q <= clamp_slots(cfg_data);
				REG_MONITOR_EN:   enable_q <= cfg_data[0];
				REG_SENDER_ID:    sender_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// scan index and held alert
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			held_valid_q <= 1'b0;
		end else begin
			if (cmd.scan_start)
				idx_q <= '0;
			else if (cmd.scan_step)
				idx_q <= idx_q + IDX_W'(1);
			if (cmd.scan_start || cmd.clear_held)
				held_valid_q <= 1'b0;
			else if (cmd.scan_step && sts.hit)
				held_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step && sts.hit) begin
			held_dest_q <= rd_dest;
			held_slot_q <= idx_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.push)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_q.alert_destination <= held_dest_q;
			out_q.alert_slot        <= 3'(held_slot_q);
			out_q.alert_sender      <= sender_q;
			out_q.last_alert        <= cmd.push_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

[rtl/multi_slot_stall_watchdog.sv]
`default_nettype none
// Enter and leave are taken while idle; a tick is dropped while monitoring is off.
// An enabled tick walks the active slots in turn in the scan loop, then a flush
// beat; the scan holds while the output side stalls a pending alert.
// A held alert moves into the output register at the next hit, or in the flush.
// arst_n clears all slot versions and destinations, active_slots to 1,
// monitoring off, sender ID to zero.
// ----------------------------------------------------------------------------
// multi_slot_stall_watchdog
// Per-slot stall watchdog: activity versions of the active slots are compared
// against the last checked version on each enabled tick and stalled slots raise one alert each.
// ----------------------------------------------------------------------------
module multi_slot_stall_watchdog (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire mswd_pkg::in_item_t             in_data,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output mswd_pkg::out_item_t                 out_data,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [mswd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                    cfg_data
);
	import mswd_pkg::*;

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	assign cfg_ready = 1'b1;

	mswd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_op    (in_data.operation),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	mswd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// an alert beat never carries an empty destination
	a_dest_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.alert_destination != 32'd0)
		else $error("alert with zero destination");

	// a push only when the output register is free or draining
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> sts.out_free)
		else $error("output register overwritten");

	// nothing is left held once input is taken again
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !sts.held_valid)
		else $error("held alert left behind after scan");

	// scan starts with no alert held
	a_start_clean: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_start |-> !sts.held_valid && !cmd.scan_step)
		else $error("scan started with stale alert");

endmodule
`default_nettype wire
